// ----- src/lbci_pkg.sv -----
// ----------------------------------------------------------------------------
// lbci_pkg
// Types and constants shared by the LED blink code indicator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lbci_pkg;

    typedef enum logic [2:0] {
        OP_TICK          = 3'd0,
        OP_OFF           = 3'd1,
        OP_ALARM         = 3'd2,
        OP_DOWNLOAD      = 3'd3,
        OP_DOWNLOAD_DONE = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        MODE_OFF      = 3'd0,
        MODE_IDLE     = 3'd1,
        MODE_BLINK    = 3'd2,
        MODE_PAUSE    = 3'd3,
        MODE_DOWNLOAD = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        COLOUR_NONE  = 2'd0,
        COLOUR_GREEN = 2'd1,
        COLOUR_RED   = 2'd2
    } colour_t;

    localparam logic [1:0] LED_STEADY = 2'd1;
    localparam logic [1:0] LED_BLINK  = 2'd2;

    localparam logic [1:0] CFG_PAUSE_LEN     = 2'd0;
    localparam logic [1:0] CFG_TICK_MS       = 2'd1;
    localparam logic [1:0] CFG_DOWNLOAD_HALF = 2'd2;

    localparam logic [15:0] RESET_PAUSE_LEN     = 16'd20;
    localparam logic [9:0]  RESET_TICK_MS       = 10'd100;
    localparam logic [14:0] RESET_DOWNLOAD_HALF = 15'd800;

    localparam logic [15:0] TIMER_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] pause_len;
        logic [9:0]  tick_ms;
        logic [14:0] download_half;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  red_blinks;
        logic [1:0]  red_style;
        logic [7:0]  green_blinks;
        logic [1:0]  green_style;
        logic [15:0] blink_interval;
    } item_t;

    typedef struct packed {
        logic [7:0]  red_blinks;
        logic [1:0]  red_style;
        logic [7:0]  green_blinks;
        logic [1:0]  green_style;
        logic [15:0] interval;
    } pattern_t;

    typedef struct packed {
        logic  red_led;
        logic  green_led;
        mode_t mode;
    } status_t;

endpackage

`default_nettype wire

// ----- src/lbci_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lbci_cfg_regs
// Configuration register file: pause length, tick length, download half period.
// ----------------------------------------------------------------------------
`default_nettype none

module lbci_cfg_regs (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [15:0]    cfg_data,
    output lbci_pkg::cfg_t      cfg
);

    lbci_pkg::cfg_t cfg_reg;
    lbci_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                lbci_pkg::CFG_PAUSE_LEN:     cfg_next.pause_len     = cfg_data;
                lbci_pkg::CFG_TICK_MS:       cfg_next.tick_ms       = cfg_data[9:0];
                lbci_pkg::CFG_DOWNLOAD_HALF: cfg_next.download_half = cfg_data[14:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pause_len     <= lbci_pkg::RESET_PAUSE_LEN;
            cfg_reg.tick_ms       <= lbci_pkg::RESET_TICK_MS;
            cfg_reg.download_half <= lbci_pkg::RESET_DOWNLOAD_HALF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/lbci_engine.sv -----
// ----------------------------------------------------------------------------
// lbci_engine
// Indicator state and its combinational update for one registered item.
// ----------------------------------------------------------------------------
`default_nettype none

module lbci_engine (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  lbci_pkg::item_t     item,
    input  lbci_pkg::cfg_t      cfg,
    output lbci_pkg::status_t   status_next
);

    lbci_pkg::mode_t    mode_reg, mode_next;
    logic [15:0]        tick_timer_reg, tick_timer_next;
    logic [7:0]         red_done_reg, red_done_next;
    logic [7:0]         green_done_reg, green_done_next;
    lbci_pkg::pattern_t pat_reg, pat_next;
    logic               red_lit_reg, red_lit_next;
    logic               green_lit_reg, green_lit_next;
    logic [15:0]        download_ms_reg, download_ms_next;
    lbci_pkg::colour_t  last_colour_reg, last_colour_next;

    logic [15:0]        timer_inc;
    logic [16:0]        dl_sum;
    logic [15:0]        dl_sat;
    lbci_pkg::colour_t  dl_colour;
    logic               green_fin;
    logic               red_fin;

    always_comb
    begin
        mode_next        = mode_reg;
        tick_timer_next  = tick_timer_reg;
        red_done_next    = red_done_reg;
        green_done_next  = green_done_reg;
        pat_next         = pat_reg;
        red_lit_next     = red_lit_reg;
        green_lit_next   = green_lit_reg;
        download_ms_next = download_ms_reg;
        last_colour_next = last_colour_reg;

        timer_inc = (tick_timer_reg == lbci_pkg::TIMER_MAX) ? tick_timer_reg
                                                            : tick_timer_reg + 16'd1;
        dl_sum    = {1'b0, download_ms_reg} + {7'd0, cfg.tick_ms};
        dl_sat    = dl_sum[16] ? lbci_pkg::TIMER_MAX : dl_sum[15:0];
        dl_colour = (dl_sat < {1'b0, cfg.download_half}) ? lbci_pkg::COLOUR_GREEN
                                                         : lbci_pkg::COLOUR_RED;
        green_fin = 1'b0;
        red_fin   = 1'b0;

        case (lbci_pkg::opcode_t'(item.opcode))
            lbci_pkg::OP_TICK:
            begin
                case (mode_reg)
                    lbci_pkg::MODE_BLINK:
                    begin
                        tick_timer_next = timer_inc;
                        if (timer_inc >= pat_reg.interval)
                        begin
                            if (pat_reg.green_style == lbci_pkg::LED_BLINK)
                            begin
                                if (green_done_reg >= pat_reg.green_blinks)
                                    green_lit_next = 1'b0;
                                else if (!green_lit_reg)
                                    green_lit_next = 1'b1;
                                else
                                begin
                                    green_lit_next  = 1'b0;
                                    green_done_next = green_done_reg + 8'd1;
                                end
                            end
                            if (pat_reg.red_style == lbci_pkg::LED_BLINK)
                            begin
                                if (red_done_reg >= pat_reg.red_blinks)
                                    red_lit_next = 1'b0;
                                else if (!red_lit_reg)
                                    red_lit_next = 1'b1;
                                else
                                begin
                                    red_lit_next  = 1'b0;
                                    red_done_next = red_done_reg + 8'd1;
                                end
                            end
                            green_fin = (pat_reg.green_style != lbci_pkg::LED_BLINK)
                                     || (green_done_next >= pat_reg.green_blinks);
                            red_fin   = (pat_reg.red_style != lbci_pkg::LED_BLINK)
                                     || (red_done_next >= pat_reg.red_blinks);
                            if (green_fin && red_fin)
                                mode_next = lbci_pkg::MODE_PAUSE;
                            tick_timer_next = 16'd0;
                        end
                    end
                    lbci_pkg::MODE_PAUSE:
                    begin
                        tick_timer_next = timer_inc;
                        if (timer_inc >= cfg.pause_len)
                        begin
                            if (pat_reg.green_style == lbci_pkg::LED_BLINK)
                                green_done_next = 8'd0;
                            if (pat_reg.red_style == lbci_pkg::LED_BLINK)
                                red_done_next = 8'd0;
                            mode_next       = lbci_pkg::MODE_BLINK;
                            tick_timer_next = 16'd0;
                        end
                    end
                    lbci_pkg::MODE_DOWNLOAD:
                    begin
                        download_ms_next = dl_sat;
                        if (dl_colour != last_colour_reg)
                        begin
                            last_colour_next = dl_colour;
                            green_lit_next   = (dl_colour == lbci_pkg::COLOUR_GREEN);
                            red_lit_next     = (dl_colour == lbci_pkg::COLOUR_RED);
                        end
                        if ({1'b0, dl_sat} >= {1'b0, cfg.download_half, 1'b0})
                            download_ms_next = 16'd0;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
            lbci_pkg::OP_OFF:
            begin
                tick_timer_next = 16'd0;
                red_done_next   = 8'd0;
                green_done_next = 8'd0;
                pat_next        = '0;
                red_lit_next    = 1'b0;
                green_lit_next  = 1'b0;
                mode_next       = lbci_pkg::MODE_OFF;
            end
            lbci_pkg::OP_ALARM:
            begin
                tick_timer_next       = 16'd0;
                red_done_next         = 8'd0;
                green_done_next       = 8'd0;
                pat_next.red_blinks   = item.red_blinks;
                pat_next.red_style    = item.red_style;
                pat_next.green_blinks = item.green_blinks;
                pat_next.green_style  = item.green_style;
                pat_next.interval     = item.blink_interval;
                red_lit_next          = (item.red_style == lbci_pkg::LED_STEADY);
                green_lit_next        = (item.green_style == lbci_pkg::LED_STEADY);
                if (item.red_style == lbci_pkg::LED_BLINK
                    || item.green_style == lbci_pkg::LED_BLINK)
                    mode_next = lbci_pkg::MODE_BLINK;
                else
                    mode_next = lbci_pkg::MODE_IDLE;
            end
            lbci_pkg::OP_DOWNLOAD:
            begin
                mode_next        = lbci_pkg::MODE_DOWNLOAD;
                download_ms_next = 16'd0;
            end
            lbci_pkg::OP_DOWNLOAD_DONE:
            begin
                mode_next = lbci_pkg::MODE_OFF;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    assign status_next.red_led   = red_lit_next;
    assign status_next.green_led = green_lit_next;
    assign status_next.mode      = mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= lbci_pkg::MODE_OFF;
            tick_timer_reg  <= 16'd0;
            red_done_reg    <= 8'd0;
            green_done_reg  <= 8'd0;
            pat_reg         <= '0;
            red_lit_reg     <= 1'b0;
            green_lit_reg   <= 1'b0;
            download_ms_reg <= 16'd0;
            last_colour_reg <= lbci_pkg::COLOUR_NONE;
        end
        else if (step)
        begin
            mode_reg        <= mode_next;
            tick_timer_reg  <= tick_timer_next;
            red_done_reg    <= red_done_next;
            green_done_reg  <= green_done_next;
            pat_reg         <= pat_next;
            red_lit_reg     <= red_lit_next;
            green_lit_reg   <= green_lit_next;
            download_ms_reg <= download_ms_next;
            last_colour_reg <= last_colour_next;
        end
    end

    a_red_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
        red_done_reg <= pat_reg.red_blinks)
        else $error("red blink count ran past its pattern");

    a_green_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
        green_done_reg <= pat_reg.green_blinks)
        else $error("green blink count ran past its pattern");

    a_off_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.opcode == lbci_pkg::OP_OFF
        |=> !red_lit_reg && !green_lit_reg && mode_reg == lbci_pkg::MODE_OFF)
        else $error("off command left an LED lit or a mode set");

    a_download_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.opcode == lbci_pkg::OP_TICK && mode_reg == lbci_pkg::MODE_DOWNLOAD
        |=> mode_reg == lbci_pkg::MODE_DOWNLOAD)
        else $error("tick moved the indicator out of download mode");

endmodule

`default_nettype wire

// ----- src/led_blink_code_indicator_core.sv -----
// ----------------------------------------------------------------------------
// led_blink_code_indicator_core
// Two-LED blink code indicator: input register, state update, result register.
// ----------------------------------------------------------------------------
//  Channel  | Handshake           | Payload
//  ---------+---------------------+------------------------------------------
//  in       | in_valid / in_ready | opcode, red_blinks, red_style, green_blinks,
//           |                     | green_style, blink_interval
//  out      | out_valid/out_ready | red_led, green_led, display_mode
//  cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One item per cycle sustained while out_ready holds; each item passes the
//  input register, then the state update into the result register.
//  The state update is a single pass of small counter and compare logic.
//  Reset puts the engine state in off mode, both LEDs dark; no clearing pass.
//  A stalled result holds the pipe; the input register still fills once.
//  Configuration writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module led_blink_code_indicator_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [2:0]   opcode,
    input  wire logic [7:0]   red_blinks,
    input  wire logic [1:0]   red_style,
    input  wire logic [7:0]   green_blinks,
    input  wire logic [1:0]   green_style,
    input  wire logic [15:0]  blink_interval,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic              red_led,
    output logic              green_led,
    output logic [2:0]        display_mode,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    logic               in_valid_reg;
    lbci_pkg::item_t    item_reg;
    logic               out_valid_reg;
    lbci_pkg::status_t  status_reg;
    lbci_pkg::status_t  status_next;
    lbci_pkg::cfg_t     cfg;
    logic               advance;
    logic               in_xfer;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    lbci_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lbci_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (item_reg),
        .cfg         (cfg),
        .status_next (status_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.opcode         <= opcode;
            item_reg.red_blinks     <= red_blinks;
            item_reg.red_style      <= red_style;
            item_reg.green_blinks   <= green_blinks;
            item_reg.green_style    <= green_style;
            item_reg.blink_interval <= blink_interval;
        end
        if (advance)
            status_reg <= status_next;
    end

    assign out_valid    = out_valid_reg;
    assign red_led      = status_reg.red_led;
    assign green_led    = status_reg.green_led;
    assign display_mode = status_reg.mode;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("held result dropped");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !out_ready |-> !advance && !in_ready)
        else $error("pipe advanced into a stalled result");

    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed item produced no result");

endmodule

`default_nettype wire

// ----- sim/blink_status_checker.sv -----
// ----------------------------------------------------------------------------
// blink_status_checker
// Watches the input, result and register channels of the blink code indicator,
// keeps its own model of the LED, timer and download state, predicts the
// status after every input transfer and compares each result transfer with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module blink_status_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         in_ready,
    input  wire logic [2:0]   opcode,
    input  wire logic [7:0]   red_blinks,
    input  wire logic [1:0]   red_style,
    input  wire logic [7:0]   green_blinks,
    input  wire logic [1:0]   green_style,
    input  wire logic [15:0]  blink_interval,
    input  wire logic         out_valid,
    input  wire logic         out_ready,
    input  wire logic         red_led,
    input  wire logic         green_led,
    input  wire logic [2:0]   display_mode,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    output int                errors,
    output int                outstanding,
    output int                results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    lbci_pkg::cfg_t     cfg;
    lbci_pkg::mode_t    mode_q;
    logic [15:0]        timer_q;
    logic [7:0]         red_done_q;
    logic [7:0]         green_done_q;
    lbci_pkg::pattern_t pat;
    logic               red_lit;
    logic               green_lit;
    logic [15:0]        dl_ms;
    lbci_pkg::colour_t  shown;
    lbci_pkg::status_t  pending_status[$];

    function automatic logic interval_elapsed(logic [15:0] limit);
        if (timer_q != lbci_pkg::TIMER_MAX)
            timer_q = timer_q + 16'd1;
        return timer_q >= limit;
    endfunction

    function automatic void clear_pattern();
        timer_q      = '0;
        red_done_q   = '0;
        green_done_q = '0;
        pat          = '0;
    endfunction

    function automatic void toggle_led(inout logic lit, inout logic [7:0] blinks,
                                       input logic [7:0] count);
        if (blinks >= count)
        begin
            lit = 1'b0;
        end
        else if (!lit)
        begin
            lit = 1'b1;
        end
        else
        begin
            lit    = 1'b0;
            blinks = blinks + 8'd1;
        end
    endfunction

    function automatic void blink_tick();
        logic green_fin;
        logic red_fin;
        if (!interval_elapsed(pat.interval))
            return;
        if (pat.green_style == lbci_pkg::LED_BLINK)
            toggle_led(green_lit, green_done_q, pat.green_blinks);
        if (pat.red_style == lbci_pkg::LED_BLINK)
            toggle_led(red_lit, red_done_q, pat.red_blinks);
        green_fin = (pat.green_style != lbci_pkg::LED_BLINK)
                 || (green_done_q >= pat.green_blinks);
        red_fin   = (pat.red_style != lbci_pkg::LED_BLINK)
                 || (red_done_q >= pat.red_blinks);
        if (green_fin && red_fin)
            mode_q = lbci_pkg::MODE_PAUSE;
        timer_q = '0;
    endfunction

    function automatic void pause_tick();
        if (!interval_elapsed(cfg.pause_len))
            return;
        if (pat.green_style == lbci_pkg::LED_BLINK)
            green_done_q = '0;
        if (pat.red_style == lbci_pkg::LED_BLINK)
            red_done_q = '0;
        mode_q  = lbci_pkg::MODE_BLINK;
        timer_q = '0;
    endfunction

    function automatic void download_tick();
        logic [16:0]       sum;
        lbci_pkg::colour_t colour;
        sum    = {1'b0, dl_ms} + {7'd0, cfg.tick_ms};
        dl_ms  = sum[16] ? lbci_pkg::TIMER_MAX : sum[15:0];
        colour = (dl_ms < {1'b0, cfg.download_half}) ? lbci_pkg::COLOUR_GREEN
                                                     : lbci_pkg::COLOUR_RED;
        if (colour != shown)
        begin
            shown     = colour;
            green_lit = (colour == lbci_pkg::COLOUR_GREEN);
            red_lit   = (colour == lbci_pkg::COLOUR_RED);
        end
        if ({1'b0, dl_ms} >= {1'b0, cfg.download_half, 1'b0})
            dl_ms = '0;
    endfunction

    function automatic lbci_pkg::status_t next_status(lbci_pkg::item_t it);
        lbci_pkg::status_t s;
        case (it.opcode)
            lbci_pkg::OP_TICK:
            begin
                case (mode_q)
                    lbci_pkg::MODE_BLINK:    blink_tick();
                    lbci_pkg::MODE_PAUSE:    pause_tick();
                    lbci_pkg::MODE_DOWNLOAD: download_tick();
                    default:                 ;
                endcase
            end
            lbci_pkg::OP_OFF:
            begin
                clear_pattern();
                red_lit   = 1'b0;
                green_lit = 1'b0;
                mode_q    = lbci_pkg::MODE_OFF;
            end
            lbci_pkg::OP_ALARM:
            begin
                clear_pattern();
                pat       = '{it.red_blinks, it.red_style, it.green_blinks,
                              it.green_style, it.blink_interval};
                red_lit   = (pat.red_style == lbci_pkg::LED_STEADY);
                green_lit = (pat.green_style == lbci_pkg::LED_STEADY);
                if (pat.red_style == lbci_pkg::LED_BLINK
                    || pat.green_style == lbci_pkg::LED_BLINK)
                    mode_q = lbci_pkg::MODE_BLINK;
                else
                    mode_q = lbci_pkg::MODE_IDLE;
            end
            lbci_pkg::OP_DOWNLOAD:
            begin
                mode_q = lbci_pkg::MODE_DOWNLOAD;
                dl_ms  = '0;
            end
            lbci_pkg::OP_DOWNLOAD_DONE:
            begin
                mode_q = lbci_pkg::MODE_OFF;
            end
            default: ;
        endcase
        s.red_led   = red_lit;
        s.green_led = green_lit;
        s.mode      = mode_q;
        return s;
    endfunction

    task automatic report_field(string field, logic [2:0] want_v, logic [2:0] got_v);
        errors++;
        $display("%0t: %s expected %0d got %0d", $time, field, want_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lbci_pkg::status_t want;
        lbci_pkg::item_t   it;
        if (!rst_n)
        begin
            cfg          = '{lbci_pkg::RESET_PAUSE_LEN, lbci_pkg::RESET_TICK_MS,
                             lbci_pkg::RESET_DOWNLOAD_HALF};
            mode_q       = lbci_pkg::MODE_OFF;
            clear_pattern();
            red_lit      = 1'b0;
            green_lit    = 1'b0;
            dl_ms        = '0;
            shown        = lbci_pkg::COLOUR_NONE;
            pending_status.delete();
            errors       = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lbci_pkg::CFG_PAUSE_LEN:     cfg.pause_len     = cfg_data;
                    lbci_pkg::CFG_TICK_MS:       cfg.tick_ms       = cfg_data[9:0];
                    lbci_pkg::CFG_DOWNLOAD_HALF: cfg.download_half = cfg_data[14:0];
                    default:                     ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                it = {opcode, red_blinks, red_style, green_blinks, green_style,
                      blink_interval};
                pending_status.push_back(next_status(it));
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_status.size() == 0)
                begin
                    errors++;
                    $display("%0t: result expected none got red %0b green %0b mode %0d",
                             $time, red_led, green_led, display_mode);
                end
                else
                begin
                    want = pending_status.pop_front();
                    if (red_led !== want.red_led)
                        report_field("red_led", 3'(want.red_led), 3'(red_led));
                    if (green_led !== want.green_led)
                        report_field("green_led", 3'(want.green_led), 3'(green_led));
                    if (display_mode !== want.mode)
                        report_field("display_mode", want.mode, display_mode);
                end
            end
        end
        outstanding = pending_status.size();
    end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives the blink code indicator through a short directed sequence and then
// random alarm, download and tick streams under several register settings,
// with random idling on both channels, a long output stall and drain pauses.
// The checker beside the block predicts and compares; this module judges.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PHASES          = 7;
    localparam int          PHASE_ITEMS     = 96;
    localparam int          RESULT_LATENCY  = 4;
    localparam int          LONG_HOLD       = 48;
    localparam int          STALL_LIMIT     = 2000;
    localparam logic [2:0]  OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0]  OP_LAST_UNUSED  = 3'd7;
    localparam logic [1:0]  LED_DARK        = 2'd0;
    localparam logic [1:0]  LED_MODE_UNUSED = 2'd3;
    localparam logic [1:0]  CFG_UNUSED      = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  opcode;
    logic [7:0]  red_blinks;
    logic [1:0]  red_style;
    logic [7:0]  green_blinks;
    logic [1:0]  green_style;
    logic [15:0] blink_interval;
    logic        out_valid;
    logic        out_ready;
    logic        red_led;
    logic        green_led;
    logic [2:0]  display_mode;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int errors;
    int outstanding;
    int results_seen;
    int items_sent;
    bit tx_burst;
    bit rx_burst;
    bit rx_hold_req;

    led_blink_code_indicator_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .red_blinks     (red_blinks),
        .red_style      (red_style),
        .green_blinks   (green_blinks),
        .green_style    (green_style),
        .blink_interval (blink_interval),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red_led        (red_led),
        .green_led      (green_led),
        .display_mode   (display_mode),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    blink_status_checker status_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .red_blinks     (red_blinks),
        .red_style      (red_style),
        .green_blinks   (green_blinks),
        .green_style    (green_style),
        .blink_interval (blink_interval),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red_led        (red_led),
        .green_led      (green_led),
        .display_mode   (display_mode),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .errors         (errors),
        .outstanding    (outstanding),
        .results_seen   (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic lbci_pkg::item_t make_item(logic [2:0] op, logic [7:0] rc,
                                                  logic [1:0] rm, logic [7:0] gc,
                                                  logic [1:0] gm, logic [15:0] iv);
        return {op, rc, rm, gc, gm, iv};
    endfunction

    function automatic lbci_pkg::item_t random_item(logic [2:0] op);
        return make_item(op, 8'($urandom), 2'($urandom), 8'($urandom), 2'($urandom),
                         16'($urandom));
    endfunction

    function automatic lbci_pkg::item_t random_alarm();
        lbci_pkg::item_t it;
        it = random_item(lbci_pkg::OP_ALARM);
        if ($urandom_range(0, 4) != 0)
            it.red_blinks = 8'($urandom_range(0, 4));
        if ($urandom_range(0, 4) != 0)
            it.green_blinks = 8'($urandom_range(0, 4));
        if ($urandom_range(0, 9) < 6)
            it.red_style = lbci_pkg::LED_BLINK;
        if ($urandom_range(0, 9) < 6)
            it.green_style = lbci_pkg::LED_BLINK;
        if ($urandom_range(0, 6) != 0)
            it.blink_interval = 16'($urandom_range(0, 3));
        return it;
    endfunction

    function automatic lbci_pkg::cfg_t setting_for(int p);
        lbci_pkg::cfg_t s;
        case (p)
            0:       s = '{16'd0,     10'd1000, 15'd1};
            1:       s = '{16'd3,     10'd100,  15'd300};
            2:       s = '{16'hFFFF,  10'd1023, 15'd32767};
            3:       s = '{16'd1,     10'd0,    15'd800};
            4:       s = '{16'd2,     10'd250,  15'd0};
            5:       s = '{16'd5,     10'd1,    15'd2};
            default: s = '{lbci_pkg::RESET_PAUSE_LEN, lbci_pkg::RESET_TICK_MS,
                           lbci_pkg::RESET_DOWNLOAD_HALF};
        endcase
        return s;
    endfunction

    task automatic send_item(lbci_pkg::item_t it);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        opcode         <= it.opcode;
        red_blinks     <= it.red_blinks;
        red_style      <= it.red_style;
        green_blinks   <= it.green_blinks;
        green_style    <= it.green_style;
        blink_interval <= it.blink_interval;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic write_reg(logic [1:0] index, logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (RESULT_LATENCY) @(negedge clk);
    endtask

    task automatic run_random(int quota);
        int done_items;
        int pick;
        int n;
        done_items = 0;
        while (done_items < quota)
        begin
            pick     = $urandom_range(0, 99);
            tx_burst = ($urandom_range(0, 5) == 0);
            rx_burst = ($urandom_range(0, 5) == 0);
            n        = $urandom_range(4, 30);
            if (pick < 55)
            begin
                send_item(random_alarm());
            end
            else if (pick < 75)
            begin
                send_item(random_item(lbci_pkg::OP_DOWNLOAD));
                n = $urandom_range(4, 40);
            end
            else if (pick < 85)
            begin
                send_item(random_item(lbci_pkg::OP_OFF));
                n = $urandom_range(0, 4);
            end
            else if (pick < 95)
            begin
                send_item(random_item(3'($urandom_range(lbci_pkg::OP_TICK,
                                                        lbci_pkg::OP_DOWNLOAD_DONE))));
                n = 0;
            end
            else
            begin
                send_item(random_item(3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED))));
                n = 0;
            end
            repeat (n) send_item(random_item(lbci_pkg::OP_TICK));
            if (pick >= 55 && pick < 75 && $urandom_range(0, 2) == 0)
            begin
                send_item(random_item(lbci_pkg::OP_DOWNLOAD_DONE));
                done_items++;
            end
            done_items += n + 1;
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // result side: random stalls, occasional long hold-off
    initial
    begin
        int stall;
        forever
        begin
            if (rx_hold_req)
            begin
                stall       = LONG_HOLD;
                rx_hold_req = 1'b0;
            end
            else if (rx_burst)
            begin
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, 3);
            end
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
            if (idle >= STALL_LIMIT)
            begin
                $display("tb_top: no transfer for %0d cycles, %0d results pending",
                         idle, outstanding);
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        lbci_pkg::cfg_t s;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        opcode         = lbci_pkg::OP_TICK;
        red_blinks     = '0;
        red_style      = LED_DARK;
        green_blinks   = '0;
        green_style    = LED_DARK;
        blink_interval = '0;
        out_ready      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = lbci_pkg::CFG_PAUSE_LEN;
        cfg_data       = '0;
        items_sent     = 0;
        tx_burst       = 1'b0;
        rx_burst       = 1'b0;
        rx_hold_req    = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_item(make_item(lbci_pkg::OP_TICK, 8'hFF, LED_MODE_UNUSED, 8'hFF,
                            LED_MODE_UNUSED, 16'hFFFF));
        send_item(make_item(OP_LAST_UNUSED, 8'hFF, lbci_pkg::LED_BLINK, 8'hFF,
                            lbci_pkg::LED_BLINK, 16'hFFFF));
        send_item(make_item(lbci_pkg::OP_ALARM, 8'd2, lbci_pkg::LED_BLINK, 8'd0,
                            lbci_pkg::LED_STEADY, 16'd0));
        repeat (5) send_item(random_item(lbci_pkg::OP_TICK));
        send_item(make_item(lbci_pkg::OP_ALARM, 8'hFF, LED_MODE_UNUSED, 8'd0,
                            lbci_pkg::LED_BLINK, 16'd0));
        repeat (2) send_item(random_item(lbci_pkg::OP_TICK));
        send_item(make_item(lbci_pkg::OP_ALARM, 8'hFF, LED_DARK, 8'hFF, LED_DARK,
                            16'hFFFF));
        send_item(random_item(lbci_pkg::OP_TICK));
        send_item(make_item(lbci_pkg::OP_ALARM, 8'd0, lbci_pkg::LED_STEADY, 8'd0,
                            lbci_pkg::LED_STEADY, 16'd0));
        send_item(random_item(lbci_pkg::OP_TICK));
        send_item(random_item(lbci_pkg::OP_DOWNLOAD));
        repeat (2) send_item(random_item(lbci_pkg::OP_TICK));
        send_item(random_item(lbci_pkg::OP_DOWNLOAD_DONE));
        send_item(random_item(lbci_pkg::OP_DOWNLOAD));
        send_item(random_item(lbci_pkg::OP_TICK));
        send_item(random_item(lbci_pkg::OP_OFF));
        send_item(make_item(OP_FIRST_UNUSED, 8'h00, LED_DARK, 8'h00, LED_DARK, 16'h0000));
        send_item(make_item(lbci_pkg::OP_ALARM, 8'hFF, lbci_pkg::LED_BLINK, 8'hFF,
                            lbci_pkg::LED_BLINK, 16'hFFFF));
        send_item(random_item(lbci_pkg::OP_TICK));
        send_item(random_item(lbci_pkg::OP_OFF));
        drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            s = setting_for(phase);
            write_reg(lbci_pkg::CFG_PAUSE_LEN, s.pause_len);
            write_reg(lbci_pkg::CFG_TICK_MS, 16'(s.tick_ms));
            write_reg(lbci_pkg::CFG_DOWNLOAD_HALF, 16'(s.download_half));
            if (phase == PHASES - 1)
                write_reg(CFG_UNUSED, 16'($urandom));
            if (phase == 1)
            begin
                // hold the result side off while items keep coming
                rx_hold_req = 1'b1;
                tx_burst    = 1'b1;
                send_item(random_alarm());
                repeat (24) send_item(random_item(lbci_pkg::OP_TICK));
                tx_burst    = 1'b0;
            end
            run_random(PHASE_ITEMS);
            drain();
        end

        $display("tb_top: %0d items over %0d register settings, %0d results compared",
                 items_sent, PHASES, results_seen);
        $display("tb_top: blink rounds, download alternation, long stall and drains exercised");
        if (errors == 0 && outstanding == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/lbci_pkg.sv
src/lbci_cfg_regs.sv
src/lbci_engine.sv
src/led_blink_code_indicator_core.sv
sim/blink_status_checker.sv
sim/tb_top.sv
